/* rtl/hmbd_pkg.sv */
// Shared types, constants and helpers for the memory bus decoder.
// Depends on nothing; all files of the block but hmbd_ram import it.
package hmbd_pkg;

  // Bus field widths
  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int OFF_W  = 24;          // offset within one 16 MB region
  localparam int WIDX_W = OFF_W - 2;   // word index within a region
  localparam int LANES  = DATA_W / 8;

  // Default memory sizes (bytes, powers of two)
  localparam int MAIN_RAM_BYTES_DEF   = 4194304;
  localparam int SHARED_RAM_BYTES_DEF = 32768;

  // Depth of the queue between decode and execute
  localparam int QUEUE_DEPTH = 2;

  // Region codes (address bits 31..24)
  localparam logic [7:0] REGION_MAIN   = 8'h02;
  localparam logic [7:0] REGION_SHARED = 8'h03;
  localparam logic [7:0] REGION_IO     = 8'h04;

  // Access direction
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Access size codes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Target codes
  localparam logic [1:0] TGT_MAIN   = 2'd0;
  localparam logic [1:0] TGT_SHARED = 2'd1;
  localparam logic [1:0] TGT_IO     = 2'd2;
  localparam logic [1:0] TGT_OPEN   = 2'd3;

  // Shared work RAM mapping modes
  localparam logic [1:0] WRAM_FULL = 2'd0;
  localparam logic [1:0] WRAM_LOW  = 2'd1;
  localparam logic [1:0] WRAM_HIGH = 2'd2;
  localparam logic [1:0] WRAM_NONE = 2'd3;

  // Configuration register index
  localparam logic REG_WRAM_MODE = 1'b0;

  // Decoded access carried from decode to execute
  typedef struct packed {
    logic              wr;       // write access
    logic [1:0]        size;     // normalized size code
    logic [1:0]        target;   // target code
    logic [1:0]        lane;     // byte lane of the aligned offset
    logic [LANES-1:0]  be;       // byte lanes touched
    logic [WIDX_W-1:0] widx;     // word index in the selected memory
    logic [ADDR_W-1:0] addr;     // original address for IO
    logic [DATA_W-1:0] wdata;    // store data masked to the size
  } item_t;

  // Mask of the data bits used by an access of the given size
  function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] size);
    logic [DATA_W-1:0] m;
    case (size)
      SZ_BYTE: m = DATA_W'(32'h0000_00FF);
      SZ_HALF: m = DATA_W'(32'h0000_FFFF);
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

/* rtl/hmbd_if.sv */
// Channel interfaces of the memory bus decoder: access requests and results.
// Depends on hmbd_pkg for widths.
interface hmbd_req_if import hmbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [1:0]        access_size;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, operation, access_size, address, write_data,
                  input ready);
  modport sink   (input valid, operation, access_size, address, write_data,
                  output ready);
endinterface

interface hmbd_rsp_if import hmbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [1:0]        target;
  logic              io_request;
  logic              io_is_write;
  logic [1:0]        io_size;
  logic [ADDR_W-1:0] io_address;
  logic [DATA_W-1:0] io_write_data;

  modport source (output valid, read_data, target, io_request, io_is_write,
                  io_size, io_address, io_write_data, input ready);
  modport sink   (input valid, read_data, target, io_request, io_is_write,
                  io_size, io_address, io_write_data, output ready);
endinterface

/* rtl/hmbd_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module hmbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/hmbd_front.sv */
// Decode side: classifies each bus access by region and mapping mode.
// Depends on hmbd_pkg and hmbd_if; feeds hmbd_queue.
module hmbd_front import hmbd_pkg::*; #(
  parameter int MAIN_RAM_BYTES   = MAIN_RAM_BYTES_DEF,
  parameter int SHARED_RAM_BYTES = SHARED_RAM_BYTES_DEF
) (
  hmbd_req_if.sink   req,
  input  logic [1:0] wram_mode,
  input  logic       q_full,
  output logic       push,
  output item_t      item
);

  localparam logic [OFF_W-1:0] MAIN_MASK = OFF_W'(MAIN_RAM_BYTES - 1);
  localparam logic [OFF_W-1:0] SH_MASK   = OFF_W'(SHARED_RAM_BYTES - 1);
  localparam logic [OFF_W-1:0] HALF_MASK = OFF_W'(SHARED_RAM_BYTES / 2 - 1);
  localparam logic [OFF_W-1:0] HALF_BASE = OFF_W'(SHARED_RAM_BYTES / 2);

  logic [7:0]       region;
  logic [OFF_W-1:0] off;
  logic [OFF_W-1:0] aoff;
  logic [OFF_W-1:0] idx;
  logic [1:0]       size;
  logic [1:0]       target;

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  assign region = req.address[ADDR_W-1:OFF_W];
  assign off    = req.address[OFF_W-1:0];

  // size code three behaves as a word
  assign size = (req.access_size == SZ_BYTE || req.access_size == SZ_HALF) ?
                req.access_size : SZ_WORD;

  // align the offset down to the access size
  always_comb begin
    case (size)
      SZ_BYTE: aoff = off;
      SZ_HALF: aoff = {off[OFF_W-1:1], 1'b0};
      default: aoff = {off[OFF_W-1:2], 2'b00};
    endcase
  end

  // region and mode classification
  always_comb begin
    if (region == REGION_MAIN) begin
      target = TGT_MAIN;
    end else if (region == REGION_SHARED && wram_mode != WRAM_NONE) begin
      target = TGT_SHARED;
    end else if (region == REGION_IO) begin
      target = TGT_IO;
    end else begin
      target = TGT_OPEN;
    end
  end

  // byte index within the mapped window (mirrored)
  always_comb begin
    if (target == TGT_MAIN) begin
      idx = aoff & MAIN_MASK;
    end else begin
      case (wram_mode)
        WRAM_FULL: idx = aoff & SH_MASK;
        WRAM_LOW:  idx = aoff & HALF_MASK;
        WRAM_HIGH: idx = HALF_BASE | (aoff & HALF_MASK);
        default:   idx = '0;
      endcase
    end
  end

  // decoded item
  always_comb begin
    item.wr     = req.operation;
    item.size   = size;
    item.target = target;
    item.lane   = aoff[1:0];
    item.widx   = idx[OFF_W-1:2];
    item.addr   = req.address;
    item.wdata  = req.write_data & size_mask(size);
    case (size)
      SZ_BYTE: item.be = LANES'(1) << aoff[1:0];
      SZ_HALF: item.be = LANES'(3) << aoff[1:0];
      default: item.be = '1;
    endcase
  end

endmodule

/* rtl/hmbd_queue.sv */
// Short FIFO of decoded accesses between decode and execute.
// Depends on hmbd_pkg for item_t and the queue depth.
module hmbd_queue import hmbd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

/* rtl/hmbd_back.sv */
// Execute side: byte-lane RAM access, result assembly and output register.
// Depends on hmbd_pkg, hmbd_if and hmbd_ram.
module hmbd_back import hmbd_pkg::*; #(
  parameter int MAIN_RAM_BYTES   = MAIN_RAM_BYTES_DEF,
  parameter int SHARED_RAM_BYTES = SHARED_RAM_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  item_t      q_head,
  output logic       pop,
  hmbd_rsp_if.source rsp
);

  localparam int MAIN_WORDS = MAIN_RAM_BYTES / LANES;
  localparam int SH_WORDS   = SHARED_RAM_BYTES / LANES;
  localparam int MAIN_AW    = $clog2(MAIN_WORDS);
  localparam int SH_AW      = $clog2(SH_WORDS);

  logic              iss_valid;
  item_t             iss;
  logic              iss_move;
  logic              out_valid;
  logic              out_free;
  logic [DATA_W-1:0] wshift;
  logic [DATA_W-1:0] main_rd;
  logic [DATA_W-1:0] sh_rd;
  logic [DATA_W-1:0] word_rd;
  logic [DATA_W-1:0] rd_val;
  logic              main_re;
  logic              sh_re;
  logic [LANES-1:0]  main_we;
  logic [LANES-1:0]  sh_we;

  // handshake between issue stage and output register
  assign out_free = !out_valid || rsp.ready;
  assign iss_move = iss_valid && out_free;
  assign pop      = q_valid && (!iss_valid || iss_move);

  // memory controls for the access leaving the queue
  assign wshift  = q_head.wdata << {q_head.lane, 3'b000};
  assign main_re = pop && !q_head.wr && q_head.target == TGT_MAIN;
  assign sh_re   = pop && !q_head.wr && q_head.target == TGT_SHARED;
  assign main_we = (pop && q_head.wr && q_head.target == TGT_MAIN) ?
                   q_head.be : '0;
  assign sh_we   = (pop && q_head.wr && q_head.target == TGT_SHARED) ?
                   q_head.be : '0;

  // one byte-wide RAM per lane for each memory
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    hmbd_ram #(.WIDTH(8), .DEPTH(MAIN_WORDS)) u_main_ram (
      .clk   (clk),
      .we    (main_we[j]),
      .re    (main_re),
      .addr  (q_head.widx[MAIN_AW-1:0]),
      .wdata (wshift[8*j +: 8]),
      .rdata (main_rd[8*j +: 8])
    );
    hmbd_ram #(.WIDTH(8), .DEPTH(SH_WORDS)) u_sh_ram (
      .clk   (clk),
      .we    (sh_we[j]),
      .re    (sh_re),
      .addr  (q_head.widx[SH_AW-1:0]),
      .wdata (wshift[8*j +: 8]),
      .rdata (sh_rd[8*j +: 8])
    );
  end

  // issue stage: waits for the RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_valid <= 1'b0;
    end else if (pop) begin
      iss_valid <= 1'b1;
    end else if (iss_move) begin
      iss_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      iss <= q_head;
    end
  end

  // realign read lanes to the access
  assign word_rd = (iss.target == TGT_MAIN) ? main_rd : sh_rd;
  always_comb begin
    if (!iss.wr && (iss.target == TGT_MAIN || iss.target == TGT_SHARED)) begin
      rd_val = (word_rd >> {iss.lane, 3'b000}) & size_mask(iss.size);
    end else begin
      rd_val = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (iss_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (iss_move) begin
      rsp.read_data <= rd_val;
      rsp.target    <= iss.target;
      if (iss.target == TGT_IO) begin
        rsp.io_request    <= 1'b1;
        rsp.io_is_write   <= iss.wr;
        rsp.io_size       <= iss.size;
        rsp.io_address    <= iss.addr;
        rsp.io_write_data <= iss.wr ? iss.wdata : '0;
      end else begin
        rsp.io_request    <= 1'b0;
        rsp.io_is_write   <= 1'b0;
        rsp.io_size       <= SZ_BYTE;
        rsp.io_address    <= '0;
        rsp.io_write_data <= '0;
      end
    end
  end

  assign rsp.valid = out_valid;

endmodule

/* rtl/handheld_arm9_memory_bus_decode.sv */
// Top level of the memory bus decoder: config port, decode, queue, execute.
// Depends on hmbd_pkg, hmbd_if, hmbd_front, hmbd_queue, hmbd_back, hmbd_ram.
//
// Usage:
//   req carries one CPU bus access per word (operation, size, address, data);
//   rsp returns one result word per access in order: read data, target and
//   the IO forwarding fields for region 0x04. The user must write wram_mode
//   over APB at byte address 0 while the block is idle; it is not enforced.
// Each access passes the queue, the issue stage and the output register.
// Throughput: one access per cycle while rsp.ready holds, set by the single
//   port of each byte-lane RAM (a read or a write per cycle).
// Main RAM and shared work RAM are four byte-wide lanes each, so partial
//   writes need no read-modify-write. Memory sizes must be powers of two.
// Reset clears the queue, the pipeline valid bits and wram_mode (full
//   mapping, 32 KB by default). RAM contents are undefined until written.
// When the receiver stalls, the output word holds, the issue stage and the
//   two-entry queue fill, and req.ready drops once the queue is full.
module handheld_arm9_memory_bus_decode import hmbd_pkg::*; #(
  parameter int MAIN_RAM_BYTES   = MAIN_RAM_BYTES_DEF,
  parameter int SHARED_RAM_BYTES = SHARED_RAM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hmbd_req_if.sink    req,
  hmbd_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] wram_mode;
  logic       push;
  item_t      push_item;
  logic       q_full;
  logic       q_valid;
  item_t      q_head;
  logic       pop;
  logic       reg_sel;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_WRAM_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      wram_mode <= WRAM_FULL;
    end else if (psel && penable && pwrite && reg_sel) begin
      wram_mode <= pwdata[1:0];
    end
  end

  assign prdata = reg_sel ? {30'd0, wram_mode} : 32'd0;

  // decode
  hmbd_front #(
    .MAIN_RAM_BYTES   (MAIN_RAM_BYTES),
    .SHARED_RAM_BYTES (SHARED_RAM_BYTES)
  ) u_front (
    .req       (req),
    .wram_mode (wram_mode),
    .q_full    (q_full),
    .push      (push),
    .item      (push_item)
  );

  // queue between decode and execute
  hmbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // execute
  hmbd_back #(
    .MAIN_RAM_BYTES   (MAIN_RAM_BYTES),
    .SHARED_RAM_BYTES (SHARED_RAM_BYTES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule
